// ===== rtl/core/pre_pkg.sv =====
// shared types and constants of the printable run extractor
package pre_pkg;

   localparam int BYTE_W         = 8;
   localparam int OFFSET_W       = 32;
   localparam int MIN_LEN_W      = 5;
   localparam int HOLD_DEPTH_DEF = 32;

   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 5'd4;

   // printable, non-space range
   localparam logic [BYTE_W-1:0] PRINT_LO = 8'h21;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7e;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH_RD,
      ST_FLUSH_WR,
      ST_EMIT_BYTE,
      ST_EMIT_END
   } pre_state_type;

endpackage

// ===== rtl/core/printable_run_extractor_top.sv =====
// top level of the printable run extractor: run tracking, flush sequencer, result register
//
// Scans a byte stream one transaction at a time and reports runs of printable non-space bytes
// (0x21 to 0x7e) longer than csr_min_len, each result tagged with the offset of the run's
// first byte. csr_min_len is clamped to HOLD_DEPTH-1 and may only be written while the block
// is idle. States per input transaction, with an unstalled result side: a byte that produces
// nothing is taken in ST_IDLE alone; a byte of an already reported run adds ST_EMIT_BYTE; the
// byte that makes a run long enough first flushes the held bytes, each read from the hold RAM in
// ST_FLUSH_RD and loaded into the result register in ST_FLUSH_WR; an end marker adds ST_EMIT_END.
// The input is stalled while a transaction's results are being produced, but a finished result
// may sit in the output register while the next transaction is taken. No clearing pass is
// needed after reset: only hold entries written earlier in the same run are ever read.
module printable_run_extractor_top #(
   parameter int HOLD_DEPTH = pre_pkg::HOLD_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input transactions
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pre_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                              req_buffer_end,
   // result transactions
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pre_pkg::OFFSET_W-1:0]      rsp_run_offset,
   output logic [pre_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_end_of_run,
   output logic                              rsp_last_of_item,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pre_pkg::MIN_LEN_W-1:0]     csr_min_len
);

   localparam int ADDR_W = $clog2(HOLD_DEPTH);
   // run length counts up to HOLD_DEPTH
   localparam int LEN_W  = $clog2(HOLD_DEPTH + 1);
   localparam int CMP_W  = (LEN_W > pre_pkg::MIN_LEN_W) ? LEN_W : pre_pkg::MIN_LEN_W;

   // control state
   pre_pkg::pre_state_type        state_ff, state_in;
   logic [pre_pkg::MIN_LEN_W-1:0] min_len_ff, min_len_in;
   logic [pre_pkg::OFFSET_W-1:0]  byte_offset_ff, byte_offset_in;
   logic [pre_pkg::OFFSET_W-1:0]  run_start_ff, run_start_in;
   logic [LEN_W-1:0]              run_length_ff, run_length_in;
   logic                          run_reported_ff, run_reported_in;
   logic [ADDR_W-1:0]             flush_idx_ff, flush_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // latched transaction payload
   logic [pre_pkg::BYTE_W-1:0]    cur_byte_ff, cur_byte_in;
   logic                          cur_last_ff, cur_last_in;

   // result register payload
   logic [pre_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [pre_pkg::BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_eor_ff, rsp_eor_in;
   logic                          rsp_lst_ff, rsp_lst_in;

   logic                          req_accept;
   logic                          out_free;
   logic                          printable;
   logic [CMP_W-1:0]              lim_wide;
   logic [LEN_W-1:0]              lim;
   logic                          hold_room;
   logic                          flush_done;

   // sequencer outputs
   logic                          load_out;
   logic [pre_pkg::BYTE_W-1:0]    load_byte;
   logic                          load_eor;
   logic                          load_lst;
   logic                          rd_en;
   logic                          wr_en;
   logic [pre_pkg::BYTE_W-1:0]    rd_data;

   assign req_stall  = (state_ff != pre_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // result register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign printable = (req_in_byte >= pre_pkg::PRINT_LO) && (req_in_byte <= pre_pkg::PRINT_HI);

   // clamp the minimum length to what the hold store can keep
   assign lim_wide = (CMP_W'(min_len_ff) > CMP_W'(HOLD_DEPTH - 1)) ?
                     CMP_W'(HOLD_DEPTH - 1) : CMP_W'(min_len_ff);
   assign lim      = lim_wide[LEN_W-1:0];

   assign hold_room  = (run_length_ff < lim);
   assign flush_done = ((LEN_W'(flush_idx_ff) + LEN_W'(1)) == lim);

   // held prefix of the current run; writes land at accept, reads come only in the flush
   // states while the input is stalled, so the same entry is never written and read in the same cycle
   pre_hold_ram #(
      .DEPTH (HOLD_DEPTH)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (run_length_ff[ADDR_W-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (rd_en),
      .rd_addr (flush_idx_ff),
      .rd_data (rd_data)
   );

   // run tracking, updated once per accepted transaction; flush index also steps in ST_FLUSH_WR
   always_comb begin
      min_len_in      = min_len_ff;
      byte_offset_in  = byte_offset_ff;
      run_start_in    = run_start_ff;
      run_length_in   = run_length_ff;
      run_reported_in = run_reported_ff;
      cur_byte_in     = cur_byte_ff;
      cur_last_in     = cur_last_ff;
      flush_idx_in    = flush_idx_ff;
      wr_en           = 1'b0;

      if (csr_valid && csr_ready) begin
         min_len_in = csr_min_len;
      end

      if (req_accept) begin
         cur_byte_in  = req_in_byte;
         cur_last_in  = req_buffer_end;
         flush_idx_in = '0;
         if (printable) begin
            if ((run_length_ff == '0) && !run_reported_ff) begin
               run_start_in = byte_offset_ff;
            end
            if (!run_reported_ff) begin
               if (hold_room) begin
                  wr_en         = 1'b1;
                  run_length_in = run_length_ff + LEN_W'(1);
               end else begin
                  run_reported_in = 1'b1;
                  run_length_in   = lim + LEN_W'(1);
               end
            end
         end else begin
            run_length_in   = '0;
            run_reported_in = 1'b0;
         end
         byte_offset_in = byte_offset_ff + pre_pkg::OFFSET_W'(1);
         // buffer end drops the run and restarts the offsets
         if (req_buffer_end) begin
            run_length_in   = '0;
            run_reported_in = 1'b0;
            byte_offset_in  = '0;
         end
      end else if ((state_ff == pre_pkg::ST_FLUSH_WR) && out_free) begin
         flush_idx_in = flush_idx_ff + ADDR_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pre_pkg::ST_IDLE: begin
            if (req_accept) begin
               priority if (printable && run_reported_ff) begin
                  state_in = pre_pkg::ST_EMIT_BYTE;
               end else if (printable && !hold_room) begin
                  state_in = (lim == '0) ? pre_pkg::ST_EMIT_BYTE : pre_pkg::ST_FLUSH_RD;
               end else if (!printable && run_reported_ff) begin
                  state_in = pre_pkg::ST_EMIT_END;
               end else begin
                  state_in = pre_pkg::ST_IDLE;
               end
            end
         end
         pre_pkg::ST_FLUSH_RD: begin
            state_in = pre_pkg::ST_FLUSH_WR;
         end
         pre_pkg::ST_FLUSH_WR: begin
            if (out_free) begin
               state_in = flush_done ? pre_pkg::ST_EMIT_BYTE : pre_pkg::ST_FLUSH_RD;
            end
         end
         pre_pkg::ST_EMIT_BYTE: begin
            if (out_free) begin
               state_in = cur_last_ff ? pre_pkg::ST_EMIT_END : pre_pkg::ST_IDLE;
            end
         end
         pre_pkg::ST_EMIT_END: begin
            if (out_free) begin
               state_in = pre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pre_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      load_out  = 1'b0;
      load_byte = '0;
      load_eor  = 1'b0;
      load_lst  = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         pre_pkg::ST_IDLE: begin
            load_out = 1'b0;
         end
         pre_pkg::ST_FLUSH_RD: begin
            rd_en = 1'b1;
         end
         pre_pkg::ST_FLUSH_WR: begin
            load_out  = out_free;
            load_byte = rd_data;
         end
         pre_pkg::ST_EMIT_BYTE: begin
            load_out  = out_free;
            load_byte = cur_byte_ff;
            load_lst  = !cur_last_ff;
         end
         pre_pkg::ST_EMIT_END: begin
            load_out = out_free;
            load_eor = 1'b1;
            load_lst = 1'b1;
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_eor_in    = rsp_eor_ff;
      rsp_lst_in    = rsp_lst_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = run_start_ff;
         rsp_byte_in   = load_byte;
         rsp_eor_in    = load_eor;
         rsp_lst_in    = load_lst;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pre_pkg::ST_IDLE;
         min_len_ff      <= pre_pkg::MIN_LEN_RESET;
         byte_offset_ff  <= '0;
         run_start_ff    <= '0;
         run_length_ff   <= '0;
         run_reported_ff <= 1'b0;
         flush_idx_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         min_len_ff      <= min_len_in;
         byte_offset_ff  <= byte_offset_in;
         run_start_ff    <= run_start_in;
         run_length_ff   <= run_length_in;
         run_reported_ff <= run_reported_in;
         flush_idx_ff    <= flush_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cur_byte_ff   <= cur_byte_in;
      cur_last_ff   <= cur_last_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_eor_ff    <= rsp_eor_in;
      rsp_lst_ff    <= rsp_lst_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_run_offset   = rsp_offset_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_end_of_run   = rsp_eor_ff;
   assign rsp_last_of_item = rsp_lst_ff;

   // flush never reads past the held prefix
   a_flush_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pre_pkg::ST_FLUSH_WR) |-> (LEN_W'(flush_idx_ff) < lim))
      else $error("flush index beyond held prefix");

   // an end marker carries no byte and closes the transaction
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_run) |-> ((rsp_out_byte == '0) && rsp_last_of_item))
      else $error("malformed end marker");

   // a reported run has a nonzero length
   a_reported_len: assert property (@(posedge clock) disable iff (reset)
      run_reported_ff |-> (run_length_ff != '0))
      else $error("reported run with zero length");

   // every hold read is followed by its load step
   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pre_pkg::ST_FLUSH_RD) |=> (state_ff == pre_pkg::ST_FLUSH_WR))
      else $error("hold read not followed by load");

endmodule

// ===== rtl/core/pre_hold_ram.sv =====
// hold store for the prefix of a run, one write and one registered read port
module pre_hold_ram #(
   parameter int DEPTH = pre_pkg::HOLD_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [pre_pkg::BYTE_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [pre_pkg::BYTE_W-1:0]    rd_data
);

   logic [pre_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [pre_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the printable run extractor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // hold depth of the block as built, and the wait that covers its longest flush
   localparam int HOLD_DEPTH   = pre_pkg::HOLD_DEPTH_DEF;
   localparam int DRAIN_CYCLES = 80;

   // one expected result transaction
   typedef struct packed {
      logic [pre_pkg::OFFSET_W-1:0] run_offset;
      logic [pre_pkg::BYTE_W-1:0]   out_byte;
      logic                         end_of_run;
      logic                         last_of_item;
   } run_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [pre_pkg::BYTE_W-1:0]    req_in_byte;
   logic                          req_buffer_end;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [pre_pkg::OFFSET_W-1:0]  rsp_run_offset;
   logic [pre_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_end_of_run;
   logic                          rsp_last_of_item;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [pre_pkg::MIN_LEN_W-1:0] csr_min_len;

   // predictor state: the scan as the block should see it
   logic [pre_pkg::MIN_LEN_W-1:0] min_len_q;
   logic [pre_pkg::OFFSET_W-1:0]  next_offset;
   logic [pre_pkg::OFFSET_W-1:0]  run_origin;
   logic [5:0]                    run_len;
   logic                          run_shown;
   logic [pre_pkg::BYTE_W-1:0]    held_bytes [HOLD_DEPTH];

   // results still owed by the block, oldest first
   run_result_type pending_results [$];
   run_result_type want;

   int unsigned mismatches = 0;
   int unsigned stall_left = 0;
   bit          calm;

   printable_run_extractor_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_buffer_end   (req_buffer_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_offset   (rsp_run_offset),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_min_len      (csr_min_len)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a result never shows up or a handshake hangs
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // prints one line per mismatch and counts it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatches++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
   endtask

   function automatic run_result_type make_result(input logic [pre_pkg::OFFSET_W-1:0] off,
                                                  input logic [pre_pkg::BYTE_W-1:0] b,
                                                  input logic eor);
      run_result_type r;
      r.run_offset   = off;
      r.out_byte     = b;
      r.end_of_run   = eor;
      r.last_of_item = 1'b0;
      return r;
   endfunction

   function automatic logic [pre_pkg::BYTE_W-1:0] random_printable();
      return pre_pkg::BYTE_W'($urandom_range(pre_pkg::PRINT_LO, pre_pkg::PRINT_HI));
   endfunction

   // result side: check each accepted transaction, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected, byte", rsp_out_byte, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_run_offset !== want.run_offset)
               report_mismatch("run_offset", rsp_run_offset, want.run_offset);
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", rsp_end_of_run, want.end_of_run);
            if (rsp_last_of_item !== want.last_of_item)
               report_mismatch("last_of_item", rsp_last_of_item, want.last_of_item);
         end
      end
      // stall bursts, with plain stretches in between
      if (calm) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offers one byte, waits for its transaction, then predicts the results it causes;
   // valid stays high unless a sender gap burst drops it, so a following call sees no dip
   task automatic scan_byte(input logic [pre_pkg::BYTE_W-1:0] b, input logic last);
      run_result_type burst [$];
      int unsigned lim;
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_buffer_end <= last;
      do @(posedge clock); while (req_stall);

      lim = (min_len_q > HOLD_DEPTH - 1) ? HOLD_DEPTH - 1 : min_len_q;
      if (b >= pre_pkg::PRINT_LO && b <= pre_pkg::PRINT_HI) begin
         if (run_len == 0 && !run_shown)
            run_origin = next_offset;
         if (run_shown) begin
            // run already reported: byte passes straight through
            burst.push_back(make_result(run_origin, b, 1'b0));
         end else if (run_len < lim) begin
            held_bytes[run_len] = b;
            run_len++;
         end else begin
            // run just got long enough: flush the held prefix, then this byte
            for (int unsigned i = 0; i < lim; i++)
               burst.push_back(make_result(run_origin, held_bytes[i], 1'b0));
            burst.push_back(make_result(run_origin, b, 1'b0));
            run_shown = 1'b1;
            run_len   = 6'(lim + 1);
         end
      end else begin
         // any other byte closes the run; short runs vanish silently
         if (run_shown)
            burst.push_back(make_result(run_origin, '0, 1'b1));
         run_len   = '0;
         run_shown = 1'b0;
      end
      next_offset++;

      // buffer end: a reported run still open gets its marker, offsets restart
      if (last) begin
         if (run_shown)
            burst.push_back(make_result(run_origin, '0, 1'b1));
         run_len     = '0;
         run_shown   = 1'b0;
         next_offset = '0;
      end

      if (burst.size() != 0)
         burst[burst.size()-1].last_of_item = 1'b1;
      foreach (burst[i])
         pending_results.push_back(burst[i]);

      // sender gap burst
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit end_on_last);
      for (int i = 0; i < s.len(); i++)
         scan_byte(s[i], end_on_last && i == s.len() - 1);
   endtask

   task automatic send_random_run(input int unsigned n, input bit end_on_last);
      for (int unsigned i = 0; i < n; i++)
         scan_byte(random_printable(), end_on_last && i == n - 1);
   endtask

   // stop sending, let every owed result arrive, then let a flush in flight settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_len(input logic [pre_pkg::MIN_LEN_W-1:0] value);
      drain();
      csr_valid   <= 1'b1;
      csr_min_len <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_len_q = value;
   endtask

   // random stream: mostly printable runs around the threshold with separators,
   // the rest raw bytes; buffer ends now and then
   task automatic random_stream(input int unsigned items);
      int unsigned sent;
      int unsigned run_bytes;
      logic [pre_pkg::BYTE_W-1:0] sep;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) < 7) begin
            run_bytes = $urandom_range(0, min_len_q + 3);
            send_random_run(run_bytes, $urandom_range(0, 7) == 0);
            sep = $urandom_range(0, 1) ? pre_pkg::BYTE_W'($urandom_range(0, 8'h20))
                                       : pre_pkg::BYTE_W'($urandom_range(8'h7f, 8'hff));
            scan_byte(sep, $urandom_range(0, 9) == 0);
            sent += run_bytes + 1;
         end else begin
            scan_byte(pre_pkg::BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            sent++;
         end
      end
   endtask

   // reset threshold: short run, reported run, range edges, three buffer-end cases
   task automatic test_default_threshold();
      send_text("ab", 1'b0);
      scan_byte(8'h20, 1'b0);            // space: short run dropped
      send_text("hello", 1'b0);          // fifth byte flushes the held four
      scan_byte(pre_pkg::PRINT_LO, 1'b0); // passthrough at the low edge
      scan_byte(pre_pkg::PRINT_HI, 1'b0); // passthrough at the high edge
      scan_byte(8'h7f, 1'b0);            // just above the range: end marker
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hff, 1'b0);
      send_text("ABCDEF", 1'b1);         // buffer end on a run byte: byte then marker
      send_text("WXYZ!", 1'b0);
      scan_byte(8'h0a, 1'b1);            // buffer end on a separator: one marker only
      scan_byte(8'h80, 1'b1);            // buffer end with nothing open
   endtask

   // zero threshold: every printable byte is reported at once
   task automatic test_zero_threshold();
      write_min_len('0);
      scan_byte(pre_pkg::PRINT_LO, 1'b0);
      scan_byte("x", 1'b0);
      scan_byte(8'h20, 1'b0);
      scan_byte("q", 1'b1);              // single-byte run closed by buffer end
      scan_byte(8'h00, 1'b1);
   endtask

   // top threshold: a full hold store, and the item that causes the most results
   task automatic test_full_hold();
      write_min_len('1);
      send_random_run(31, 1'b0);         // exactly at the threshold: nothing
      scan_byte(8'h20, 1'b0);
      send_random_run(32, 1'b1);         // flush of 31, the byte, then the marker
      send_random_run(34, 1'b0);
      scan_byte(8'h09, 1'b0);
   endtask

   // several threshold settings, with one full pause in the middle of each
   task automatic test_random_runs();
      logic [pre_pkg::MIN_LEN_W-1:0] settings [4];
      settings[0] = pre_pkg::MIN_LEN_W'($urandom_range(0, 3));
      settings[1] = pre_pkg::MIN_LEN_W'($urandom_range(4, 12));
      settings[2] = pre_pkg::MIN_LEN_W'($urandom_range(13, 31));
      settings[3] = pre_pkg::MIN_LEN_RESET;
      foreach (settings[p]) begin
         write_min_len(settings[p]);
         random_stream(8);
         drain();
         random_stream(8);
      end
   endtask

   // closing stretch with no idling on either side
   task automatic test_calm_tail();
      write_min_len(pre_pkg::MIN_LEN_W'($urandom_range(1, 6)));
      calm = 1'b1;
      random_stream(20);
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_in_byte    <= '0;
      req_buffer_end <= 1'b0;
      csr_valid      <= 1'b0;
      csr_min_len    <= pre_pkg::MIN_LEN_RESET;
      calm        = 1'b0;
      min_len_q   = pre_pkg::MIN_LEN_RESET;
      next_offset = '0;
      run_origin  = '0;
      run_len     = '0;
      run_shown   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_threshold();
      test_zero_threshold();
      test_full_hold();
      test_random_runs();
      test_calm_tail();

      // wait out every owed transaction plus the block's longest flush
      drain();
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
